### rtl/bis_pkg.sv
package bis_pkg;

    localparam int CAPACITY = 16;
    localparam int ID_BITS  = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] id_value;
        logic [3:0]  read_index;
    } req_t;

    typedef struct packed {
        logic        status;
        logic        found;
        logic [3:0]  position;
        logic [15:0] read_id;
        logic [4:0]  count;
        logic        is_full;
        logic        is_empty;
    } rsp_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [ID_BITS-1:0] id;
        logic [3:0]         ridx;
        logic               hit;
        logic [IDX_W-1:0]   pos;
        logic               rhit;
        logic [ID_BITS-1:0] rdata;
    } tok_t;

    function automatic logic [ID_BITS-1:0] to_id(input logic [15:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[ID_BITS-1:0];
    endfunction

    function automatic logic [15:0] from_id(input logic [ID_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[15:0];
    endfunction

endpackage

### rtl/bounded_id_set.sv
// Set of up to CAPACITY distinct identifiers kept as a packed list in a row
// of cells, one entry per cell. A request enters as a token that walks the
// row one cell per cycle, picking up the match position and the read data;
// once it leaves the last cell the add, the delete compaction (all later
// entries move down one cell together) and the new count are applied and
// the response is registered. One request is in flight at a time: req_stall
// holds off a new request from acceptance until the result is applied,
// after the token's walk along the row, so a new request is not taken
// before the previous one is through.
module bounded_id_set (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bis_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bis_pkg::rsp_t rsp
);

    localparam int CAP = bis_pkg::CAPACITY;

    logic                        tok_v [CAP+1];
    bis_pkg::tok_t               tok   [CAP+1];
    logic [bis_pkg::ID_BITS-1:0] data  [CAP];
    logic                        load_en  [CAP];
    logic                        shift_en [CAP];

    logic                        busy_reg;
    logic                        done_valid_reg;
    bis_pkg::tok_t               done_tok_reg;
    logic [bis_pkg::CNT_W-1:0]   count_reg;
    logic [bis_pkg::CNT_W-1:0]   count_next;
    logic                        rsp_valid_reg;
    bis_pkg::rsp_t               rsp_reg;
    bis_pkg::rsp_t               rsp_next;
    logic                        apply;
    logic                        add_ok;
    logic                        del_ok;
    logic                        accept;
    logic [31:0]                 pos_wide;
    logic [31:0]                 cnt_wide;

    assign accept    = req_valid && !req_stall;
    assign req_stall = busy_reg;

    always_comb
    begin
        tok[0]       = '0;
        tok[0].mode  = req.mode;
        tok[0].id    = bis_pkg::to_id(req.id_value);
        tok[0].ridx  = req.read_index;
    end
    assign tok_v[0] = accept;

    for (genvar g = 0; g < CAP; g++)
    begin : g_cell
        logic [bis_pkg::ID_BITS-1:0] shift_src;
        if (g < CAP - 1)
        begin : g_mid
            assign shift_src = data[g+1];
        end
        else
        begin : g_end
            assign shift_src = data[g];
        end

        assign load_en[g]  = apply && add_ok && (count_reg == bis_pkg::CNT_W'(g));
        assign shift_en[g] = apply && del_ok
                             && (bis_pkg::IDX_W'(g) >= done_tok_reg.pos)
                             && ((g + 1) < 32'(count_reg));

        bis_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cell_index    (bis_pkg::IDX_W'(g)),
            .count         (count_reg),
            .tok_valid_in  (tok_v[g]),
            .tok_in        (tok[g]),
            .tok_valid_out (tok_v[g+1]),
            .tok_out       (tok[g+1]),
            .load_en       (load_en[g]),
            .load_data     (done_tok_reg.id),
            .shift_en      (shift_en[g]),
            .shift_data    (shift_src),
            .data_out      (data[g])
        );
    end

    assign apply  = done_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign add_ok = (done_tok_reg.mode == bis_pkg::MODE_ADD)
                    && (32'(count_reg) < CAP) && !done_tok_reg.hit;
    assign del_ok = (done_tok_reg.mode == bis_pkg::MODE_DELETE) && done_tok_reg.hit;

    always_comb
    begin
        count_next = count_reg;
        rsp_next   = '0;
        pos_wide   = 32'(done_tok_reg.pos);
        unique case (done_tok_reg.mode)
            bis_pkg::MODE_ADD:
            begin
                rsp_next.status = !add_ok;
                if (add_ok)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            bis_pkg::MODE_DELETE:
            begin
                rsp_next.status = !del_ok;
                if (del_ok)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            bis_pkg::MODE_LOOKUP:
            begin
                rsp_next.found = done_tok_reg.hit;
                if (done_tok_reg.hit)
                begin
                    rsp_next.position = pos_wide[3:0];
                end
            end
            default:
            begin
                rsp_next.status = !done_tok_reg.rhit;
                if (done_tok_reg.rhit)
                begin
                    rsp_next.read_id = bis_pkg::from_id(done_tok_reg.rdata);
                end
            end
        endcase
        cnt_wide          = 32'(count_next);
        rsp_next.count    = cnt_wide[4:0];
        rsp_next.is_full  = (cnt_wide == CAP);
        rsp_next.is_empty = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            done_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (apply)
            begin
                busy_reg <= 1'b0;
            end

            if (tok_v[CAP])
            begin
                done_valid_reg <= 1'b1;
            end
            else if (apply)
            begin
                done_valid_reg <= 1'b0;
            end

            if (apply)
            begin
                rsp_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_v[CAP])
        begin
            done_tok_reg <= tok[CAP];
        end
        if (apply)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/bis_cell.sv
module bis_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [bis_pkg::IDX_W-1:0]   cell_index,
    input  logic [bis_pkg::CNT_W-1:0]   count,
    input  logic                        tok_valid_in,
    input  bis_pkg::tok_t               tok_in,
    output logic                        tok_valid_out,
    output bis_pkg::tok_t               tok_out,
    input  logic                        load_en,
    input  logic [bis_pkg::ID_BITS-1:0] load_data,
    input  logic                        shift_en,
    input  logic [bis_pkg::ID_BITS-1:0] shift_data,
    output logic [bis_pkg::ID_BITS-1:0] data_out
);

    logic [bis_pkg::ID_BITS-1:0] data_reg;
    logic                        tok_valid_reg;
    bis_pkg::tok_t               tok_reg;
    bis_pkg::tok_t               tok_next;
    logic                        in_range;

    assign in_range = bis_pkg::CNT_W'(cell_index) < count;

    always_comb
    begin
        tok_next = tok_in;
        if (in_range && !tok_in.hit && (data_reg == tok_in.id))
        begin
            tok_next.hit = 1'b1;
            tok_next.pos = cell_index;
        end
        if (in_range && (tok_in.mode == bis_pkg::MODE_READ)
            && (32'(tok_in.ridx) == 32'(cell_index)))
        begin
            tok_next.rhit  = 1'b1;
            tok_next.rdata = data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_valid_in)
        begin
            tok_reg <= tok_next;
        end
        if (load_en)
        begin
            data_reg <= load_data;
        end
        else if (shift_en)
        begin
            data_reg <= shift_data;
        end
    end

    assign tok_valid_out = tok_valid_reg;
    assign tok_out       = tok_reg;
    assign data_out      = data_reg;

endmodule

### tb/tb_bounded_id_set.sv
module tb_bounded_id_set;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS  = 1730;
    localparam int QUIET_AFTER   = 1550;
    localparam int HOLD_AT       = 700;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 2 * bis_pkg::CAPACITY + 8;
    localparam int REPORT_LIMIT  = 10;

    class id_set_scoreboard;
        logic [15:0]   ids [bis_pkg::CAPACITY];
        int unsigned   held;
        bis_pkg::rsp_t expected [$];
        int unsigned   reqs;
        int unsigned   rsps;
        int unsigned   per_mode [4];
        int unsigned   rejects;
        int unsigned   times_full;
        int unsigned   times_emptied;
        int unsigned   mismatches;

        function automatic int find_id(logic [15:0] v);
            for (int i = 0; i < held; i++)
                if (ids[i] == v)
                    return i;
            return -1;
        endfunction

        function automatic string show(bis_pkg::rsp_t r);
            return $sformatf("st=%0b found=%0b pos=%0d id=%h count=%0d full=%0b empty=%0b",
                             r.status, r.found, r.position, r.read_id, r.count,
                             r.is_full, r.is_empty);
        endfunction

        function automatic void note(bis_pkg::req_t r);
            bis_pkg::rsp_t e;
            int            hit;
            e = '0;
            case (r.mode)
                bis_pkg::MODE_ADD:
                begin
                    if (held >= bis_pkg::CAPACITY || find_id(r.id_value) >= 0)
                        e.status = 1'b1;
                    else
                    begin
                        ids[held] = r.id_value;
                        held++;
                        if (held == bis_pkg::CAPACITY)
                            times_full++;
                    end
                end
                bis_pkg::MODE_DELETE:
                begin
                    hit = find_id(r.id_value);
                    if (hit < 0)
                        e.status = 1'b1;
                    else
                    begin
                        // close the gap so the list stays packed
                        for (int k = hit; k + 1 < held; k++)
                            ids[k] = ids[k + 1];
                        held--;
                        if (held == 0)
                            times_emptied++;
                    end
                end
                bis_pkg::MODE_LOOKUP:
                begin
                    hit = find_id(r.id_value);
                    if (hit >= 0)
                    begin
                        e.found    = 1'b1;
                        e.position = 4'(hit);
                    end
                end
                default:
                begin
                    if (r.read_index < held)
                        e.read_id = ids[r.read_index];
                    else
                        e.status = 1'b1;
                end
            endcase
            e.count    = 5'(held);
            e.is_full  = (held == bis_pkg::CAPACITY);
            e.is_empty = (held == 0);
            if (e.status)
                rejects++;
            per_mode[r.mode]++;
            reqs++;
            expected.push_back(e);
        endfunction

        function automatic void check(bis_pkg::rsp_t got);
            bis_pkg::rsp_t e;
            rsps++;
            if (expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%t unexpected response: %s", $realtime, show(got));
                return;
            end
            e = expected.pop_front();
            if (got.status !== e.status || got.found !== e.found
                || got.position !== e.position || got.read_id !== e.read_id
                || got.count !== e.count || got.is_full !== e.is_full
                || got.is_empty !== e.is_empty)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%t response %0d mismatch", $realtime, rsps);
                    $display("    expected %s", show(e));
                    $display("    actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic          clk = 1'b0;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    bis_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_stall;
    bis_pkg::rsp_t rsp;

    id_set_scoreboard sb = new();
    bit               draining;
    bit               held_off;
    int unsigned      idle_run;

    bounded_id_set u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    function automatic bit may_idle(int unsigned n);
        return n < QUIET_AFTER && n % 256 < 192;
    endfunction

    function automatic bis_pkg::req_t make_req(logic [1:0] m, logic [15:0] v,
                                               logic [3:0] idx);
        bis_pkg::req_t r;
        r.mode       = m;
        r.id_value   = v;
        r.read_index = idx;
        return r;
    endfunction

    function automatic bis_pkg::req_t pick_request();
        bis_pkg::req_t r;
        int unsigned   roll;
        int unsigned   sel;
        int unsigned   top;
        if (sb.held == bis_pkg::CAPACITY)
            draining = 1'b1;
        else if (sb.held == 0)
            draining = 1'b0;
        roll = $urandom_range(0, 99);
        if (draining)
            r.mode = roll < 20 ? bis_pkg::MODE_ADD : roll < 62 ? bis_pkg::MODE_DELETE
                   : roll < 81 ? bis_pkg::MODE_LOOKUP : bis_pkg::MODE_READ;
        else
            r.mode = roll < 50 ? bis_pkg::MODE_ADD : roll < 62 ? bis_pkg::MODE_DELETE
                   : roll < 81 ? bis_pkg::MODE_LOOKUP : bis_pkg::MODE_READ;
        sel = $urandom_range(0, 9);
        if (sel < 4 && sb.held > 0)
            r.id_value = sb.ids[$urandom_range(0, sb.held - 1)];
        else if (sel < 8)
            r.id_value = 16'h0100 + 16'($urandom_range(0, 23));
        else if (sel == 8)
            r.id_value = 16'($urandom());
        else
            case ($urandom_range(0, 3))
                0:       r.id_value = 16'h0000;
                1:       r.id_value = 16'hFFFF;
                2:       r.id_value = 16'h8000;
                default: r.id_value = 16'h7FFF;
            endcase
        top = sb.held < 15 ? sb.held : 15;
        if ($urandom_range(0, 9) < 7)
            r.read_index = 4'($urandom_range(0, top));
        else
            r.read_index = 4'($urandom_range(0, 15));
        return r;
    endfunction

    // call at a falling edge; returns at the edge that takes the request
    task automatic send_request(bis_pkg::req_t r);
        if (may_idle(sb.reqs) && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note(req);
            if (rsp_valid && !rsp_stall)
                sb.check(rsp);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_run <= 0;
        else if (idle_run >= STALL_LIMIT)
        begin
            $display("tb_bounded_id_set: errors");
            $finish;
        end
        else
            idle_run <= idle_run + 1;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && sb.reqs >= HOLD_AT)
            begin
                // hold the response side long enough for the input to back up
                held_off = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            else if (may_idle(sb.rsps) && $urandom_range(0, 5) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    initial
    begin
        bis_pkg::req_t plan [$];
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rsp_stall = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        plan.push_back(make_req(bis_pkg::MODE_READ,   16'h0000, 4'd0));
        plan.push_back(make_req(bis_pkg::MODE_DELETE, 16'h0100, 4'd0));
        plan.push_back(make_req(bis_pkg::MODE_LOOKUP, 16'hFFFF, 4'd0));
        plan.push_back(make_req(bis_pkg::MODE_ADD,    16'h0000, 4'd0));
        plan.push_back(make_req(bis_pkg::MODE_ADD,    16'hFFFF, 4'd15));
        plan.push_back(make_req(bis_pkg::MODE_ADD,    16'hFFFF, 4'd0));
        plan.push_back(make_req(bis_pkg::MODE_LOOKUP, 16'hFFFF, 4'd0));
        plan.push_back(make_req(bis_pkg::MODE_LOOKUP, 16'h1234, 4'd0));
        plan.push_back(make_req(bis_pkg::MODE_READ,   16'h0000, 4'd1));
        plan.push_back(make_req(bis_pkg::MODE_READ,   16'hFFFF, 4'd15));
        plan.push_back(make_req(bis_pkg::MODE_DELETE, 16'h5555, 4'd0));
        plan.push_back(make_req(bis_pkg::MODE_ADD,    16'h8000, 4'd0));
        plan.push_back(make_req(bis_pkg::MODE_DELETE, 16'h0000, 4'd0));
        plan.push_back(make_req(bis_pkg::MODE_READ,   16'h0000, 4'd0));
        plan.push_back(make_req(bis_pkg::MODE_READ,   16'h0000, 4'd1));
        plan.push_back(make_req(bis_pkg::MODE_READ,   16'h0000, 4'd2));
        plan.push_back(make_req(bis_pkg::MODE_LOOKUP, 16'h8000, 4'd0));
        foreach (plan[i])
        begin
            @(negedge clk);
            send_request(plan[i]);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            @(negedge clk);
            send_request(pick_request());
        end
        @(negedge clk);
        req_valid <= 1'b0;

        while (sb.expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d requests: add %0d, delete %0d, lookup %0d, read %0d",
                 sb.reqs, sb.per_mode[bis_pkg::MODE_ADD],
                 sb.per_mode[bis_pkg::MODE_DELETE],
                 sb.per_mode[bis_pkg::MODE_LOOKUP],
                 sb.per_mode[bis_pkg::MODE_READ]);
        $display("%0d rejected, set filled %0d times and emptied %0d times, %0d mismatches",
                 sb.rejects, sb.times_full, sb.times_emptied, sb.mismatches);
        if (sb.mismatches == 0)
            $display("tb_bounded_id_set: clean");
        else
            $display("tb_bounded_id_set: errors");
        $finish;
    end

endmodule

### filelist.f
rtl/bis_pkg.sv
rtl/bis_cell.sv
rtl/bounded_id_set.sv
tb/tb_bounded_id_set.sv
